// ===== hdl/rcmg_pkg.sv =====
package rcmg_pkg;

    // Interface modes.
    localparam logic [2:0] MODE_SLEEP   = 3'd0;
    localparam logic [2:0] MODE_OFF     = 3'd1;
    localparam logic [2:0] MODE_PASSIVE = 3'd2;
    localparam logic [2:0] MODE_SAFE    = 3'd3;
    localparam logic [2:0] MODE_FULL    = 3'd4;

    // Host command codes.
    localparam logic [3:0] OP_START   = 4'd0;
    localparam logic [3:0] OP_BAUD    = 4'd1;
    localparam logic [3:0] OP_CONTROL = 4'd2;
    localparam logic [3:0] OP_SAFE    = 4'd3;
    localparam logic [3:0] OP_FULL    = 4'd4;
    localparam logic [3:0] OP_POWER   = 4'd5;
    localparam logic [3:0] OP_SPOT    = 4'd6;
    localparam logic [3:0] OP_CLEAN   = 4'd7;
    localparam logic [3:0] OP_MAX     = 4'd8;
    localparam logic [3:0] OP_DRIVE   = 4'd9;
    localparam logic [3:0] OP_MOTORS  = 4'd10;
    localparam logic [3:0] OP_LEDS    = 4'd11;
    localparam logic [3:0] OP_PLAY    = 4'd12;
    localparam logic [3:0] OP_DOCK    = 4'd13;

    // Serial opcode bytes.
    localparam logic [7:0] TX_START   = 8'd128;
    localparam logic [7:0] TX_BAUD    = 8'd129;
    localparam logic [7:0] TX_CONTROL = 8'd130;
    localparam logic [7:0] TX_SAFE    = 8'd131;
    localparam logic [7:0] TX_FULL    = 8'd132;
    localparam logic [7:0] TX_POWER   = 8'd133;
    localparam logic [7:0] TX_SPOT    = 8'd134;
    localparam logic [7:0] TX_CLEAN   = 8'd135;
    localparam logic [7:0] TX_MAX     = 8'd136;
    localparam logic [7:0] TX_DRIVE   = 8'd137;
    localparam logic [7:0] TX_MOTORS  = 8'd138;
    localparam logic [7:0] TX_LEDS    = 8'd139;
    localparam logic [7:0] TX_PLAY    = 8'd141;
    localparam logic [7:0] TX_DOCK    = 8'd143;

    // Configuration register indexes.
    localparam logic [1:0] REG_LED_BITS  = 2'd0;
    localparam logic [1:0] REG_PWR_COLOR = 2'd1;
    localparam logic [1:0] REG_PWR_INTEN = 2'd2;

    localparam logic [7:0]  BAUD_CODE_LIMIT = 8'd12;
    localparam logic [7:0]  SONG_MAX        = 8'd15;
    localparam logic [16:0] BAUD_RESET      = 17'd57600;
    localparam logic [5:0]  LED_BITS_RESET  = 6'd0;
    localparam logic [7:0]  PWR_COLOR_RESET = 8'd125;
    localparam logic [7:0]  PWR_INTEN_RESET = 8'd255;

    // One framed command: up to five bytes, index of the final byte,
    // the gate decision and the state that holds after the command.
    typedef struct packed {
        logic [4:0][7:0] bytes;
        logic [2:0]      last_idx;
        logic            acc;
        logic [2:0]      mode;
        logic [16:0]     baud;
    } t_rec;

    typedef struct packed {
        logic push;
        t_rec rec;
    } t_enq;

    typedef struct packed {
        logic empty;
        t_rec rec;
    } t_head;

    function automatic logic [16:0] baud_rate(input logic [3:0] code);
        logic [16:0] rate;
        unique case (code)
            4'd0:    rate = 17'd300;
            4'd1:    rate = 17'd600;
            4'd2:    rate = 17'd1200;
            4'd3:    rate = 17'd2400;
            4'd4:    rate = 17'd4800;
            4'd5:    rate = 17'd9600;
            4'd6:    rate = 17'd14400;
            4'd7:    rate = 17'd19200;
            4'd8:    rate = 17'd28800;
            4'd9:    rate = 17'd38400;
            4'd10:   rate = 17'd57600;
            4'd11:   rate = 17'd115200;
            default: rate = BAUD_RESET;
        endcase
        return rate;
    endfunction

endpackage

// ===== hdl/robot_command_mode_gate_encoder_unit.sv =====
// A taken command is written into the queue as one registered entry; its results reach
// the result ports once it is at the head. Commands are taken one per cycle while the
// queue has room; the back end sends one byte per cycle while the result side pops.
// The queue of P_QUEUE_DEPTH framed commands sets how far the front runs ahead.
// Reset (synchronous, active low) sets sleep mode, 57600 baud, LED bits 0,
// color 125, intensity 255, and empties the queue.
module robot_command_mode_gate_encoder_unit #(
    parameter int P_QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    // Command side.
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [3:0]           i_op,
    input  logic [7:0]           i_baud_code,
    input  logic signed [15:0]   i_velocity,
    input  logic signed [15:0]   i_turn_radius,
    input  logic                 i_main_brush_on,
    input  logic                 i_vacuum_on,
    input  logic                 i_side_brush_on,
    input  logic [7:0]           i_song_number,
    // Result side.
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic                 o_byte_valid,
    output logic [7:0]           o_tx_byte,
    output logic                 o_last_of_run,
    output logic                 o_accepted,
    output logic [2:0]           o_mode_now,
    output logic [16:0]          o_baud_rate_now
);

    // The front end checks each command against the current mode, updates the
    // mode and baud rate at once, and writes the whole framed command into the
    // queue as one entry. Because the gate decision only needs the state left
    // by the previous command, commands can be taken on consecutive cycles.
    rcmg_pkg::t_enq  enq;
    rcmg_pkg::t_head head;
    logic            deq;

    rcmg_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_push          (i_push),
        .i_full          (o_full),
        .i_op            (i_op),
        .i_baud_code     (i_baud_code),
        .i_velocity      (i_velocity),
        .i_turn_radius   (i_turn_radius),
        .i_main_brush_on (i_main_brush_on),
        .i_vacuum_on     (i_vacuum_on),
        .i_side_brush_on (i_side_brush_on),
        .i_song_number   (i_song_number),
        .o_enq           (enq)
    );

    // The queue decouples the two sides: the command side stalls only when
    // every entry holds a command whose bytes have not all gone out.
    rcmg_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (enq),
        .i_deq   (deq),
        .o_full  (o_full),
        .o_head  (head)
    );

    // The back end walks through the bytes of the oldest command, one result
    // transaction per byte, and releases the entry after its final byte. A
    // rejected command is a single result with no byte.
    rcmg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_pop           (i_pop),
        .o_deq           (deq),
        .o_empty         (o_empty),
        .o_byte_valid    (o_byte_valid),
        .o_tx_byte       (o_tx_byte),
        .o_last_of_run   (o_last_of_run),
        .o_accepted      (o_accepted),
        .o_mode_now      (o_mode_now),
        .o_baud_rate_now (o_baud_rate_now)
    );

    // A rejected command always shows as one final result carrying no byte.
    a_reject_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_accepted) |-> (o_last_of_run && !o_byte_valid))
        else $error("rejected command not framed as a single empty result");

    // Taking a byte that is not the last one leaves the rest of the run waiting.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && !o_last_of_run) |=> (!o_empty && o_accepted))
        else $error("command run broken off before its final byte");

    // A command taken in one cycle has a result waiting in the next.
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) |=> !o_empty)
        else $error("accepted command did not reach the result side");

    // The reported mode never leaves the defined range.
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_mode_now <= rcmg_pkg::MODE_FULL))
        else $error("result reports an undefined mode");

endmodule

// ===== hdl/rcmg_front.sv =====
module rcmg_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic [3:0]           i_op,
    input  logic [7:0]           i_baud_code,
    input  logic signed [15:0]   i_velocity,
    input  logic signed [15:0]   i_turn_radius,
    input  logic                 i_main_brush_on,
    input  logic                 i_vacuum_on,
    input  logic                 i_side_brush_on,
    input  logic [7:0]           i_song_number,
    output rcmg_pkg::t_enq       o_enq
);

    logic [2:0]  r_mode;
    logic [16:0] r_baud;
    logic [5:0]  r_led_bits;
    logic [7:0]  r_pwr_color;
    logic [7:0]  r_pwr_inten;

    logic          accept;
    logic          drv;
    logic          ok;
    logic [2:0]    n_mode;
    logic [16:0]   n_baud;
    rcmg_pkg::t_rec rec;

    assign accept = i_push && !i_full;
    assign drv    = (r_mode == rcmg_pkg::MODE_SAFE) || (r_mode == rcmg_pkg::MODE_FULL);

    always_comb begin
        ok            = 1'b0;
        n_mode        = r_mode;
        n_baud        = r_baud;
        rec.bytes     = '0;
        rec.last_idx  = 3'd0;
        unique case (i_op)
            rcmg_pkg::OP_START: begin
                ok = 1'b1;
                rec.bytes[0] = rcmg_pkg::TX_START;
                n_mode = rcmg_pkg::MODE_PASSIVE;
            end
            rcmg_pkg::OP_BAUD: begin
                if ((drv || r_mode == rcmg_pkg::MODE_PASSIVE) &&
                    i_baud_code < rcmg_pkg::BAUD_CODE_LIMIT) begin
                    ok = 1'b1;
                    rec.bytes[0] = rcmg_pkg::TX_BAUD;
                    rec.bytes[1] = i_baud_code;
                    rec.last_idx = 3'd1;
                    n_baud = rcmg_pkg::baud_rate(i_baud_code[3:0]);
                end
            end
            rcmg_pkg::OP_CONTROL: begin
                if (r_mode == rcmg_pkg::MODE_PASSIVE) begin
                    ok = 1'b1;
                    rec.bytes[0] = rcmg_pkg::TX_CONTROL;
                    n_mode = rcmg_pkg::MODE_SAFE;
                end
            end
            rcmg_pkg::OP_SAFE: begin
                if (r_mode == rcmg_pkg::MODE_FULL) begin
                    ok = 1'b1;
                    rec.bytes[0] = rcmg_pkg::TX_SAFE;
                    n_mode = rcmg_pkg::MODE_SAFE;
                end
            end
            rcmg_pkg::OP_FULL: begin
                if (r_mode == rcmg_pkg::MODE_SAFE) begin
                    ok = 1'b1;
                    rec.bytes[0] = rcmg_pkg::TX_FULL;
                    n_mode = rcmg_pkg::MODE_FULL;
                end
            end
            rcmg_pkg::OP_POWER: begin
                if (drv) begin
                    ok = 1'b1;
                    rec.bytes[0] = rcmg_pkg::TX_POWER;
                    n_mode = rcmg_pkg::MODE_SLEEP;
                end
            end
            rcmg_pkg::OP_SPOT: begin
                if (drv) begin
                    ok = 1'b1;
                    rec.bytes[0] = rcmg_pkg::TX_SPOT;
                    n_mode = rcmg_pkg::MODE_PASSIVE;
                end
            end
            rcmg_pkg::OP_CLEAN: begin
                if (drv) begin
                    ok = 1'b1;
                    rec.bytes[0] = rcmg_pkg::TX_CLEAN;
                    n_mode = rcmg_pkg::MODE_PASSIVE;
                end
            end
            rcmg_pkg::OP_MAX: begin
                if (drv) begin
                    ok = 1'b1;
                    rec.bytes[0] = rcmg_pkg::TX_MAX;
                    n_mode = rcmg_pkg::MODE_PASSIVE;
                end
            end
            rcmg_pkg::OP_DRIVE: begin
                if (drv) begin
                    ok = 1'b1;
                    rec.bytes[0] = rcmg_pkg::TX_DRIVE;
                    rec.bytes[1] = i_velocity[15:8];
                    rec.bytes[2] = i_velocity[7:0];
                    rec.bytes[3] = i_turn_radius[15:8];
                    rec.bytes[4] = i_turn_radius[7:0];
                    rec.last_idx = 3'd4;
                end
            end
            rcmg_pkg::OP_MOTORS: begin
                if (drv) begin
                    ok = 1'b1;
                    rec.bytes[0] = rcmg_pkg::TX_MOTORS;
                    rec.bytes[1] = {5'd0, i_main_brush_on, i_vacuum_on, i_side_brush_on};
                    rec.last_idx = 3'd1;
                end
            end
            rcmg_pkg::OP_LEDS: begin
                if (drv) begin
                    ok = 1'b1;
                    rec.bytes[0] = rcmg_pkg::TX_LEDS;
                    rec.bytes[1] = {2'd0, r_led_bits};
                    rec.bytes[2] = r_pwr_color;
                    rec.bytes[3] = r_pwr_inten;
                    rec.last_idx = 3'd3;
                end
            end
            rcmg_pkg::OP_PLAY: begin
                if (drv && i_song_number <= rcmg_pkg::SONG_MAX) begin
                    ok = 1'b1;
                    rec.bytes[0] = rcmg_pkg::TX_PLAY;
                    rec.bytes[1] = i_song_number;
                    rec.last_idx = 3'd1;
                end
            end
            rcmg_pkg::OP_DOCK: begin
                ok = 1'b1;
                rec.bytes[0] = rcmg_pkg::TX_DOCK;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        if (!ok) begin
            rec.bytes    = '0;
            rec.last_idx = 3'd0;
        end
        rec.acc  = ok;
        rec.mode = n_mode;
        rec.baud = n_baud;
    end

    assign o_enq.push = accept;
    assign o_enq.rec  = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rcmg_pkg::MODE_SLEEP;
            r_baud <= rcmg_pkg::BAUD_RESET;
        end else if (accept) begin
            r_mode <= n_mode;
            r_baud <= n_baud;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_bits  <= rcmg_pkg::LED_BITS_RESET;
            r_pwr_color <= rcmg_pkg::PWR_COLOR_RESET;
            r_pwr_inten <= rcmg_pkg::PWR_INTEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rcmg_pkg::REG_LED_BITS:  r_led_bits  <= i_cfg_data[5:0];
                rcmg_pkg::REG_PWR_COLOR: r_pwr_color <= i_cfg_data;
                rcmg_pkg::REG_PWR_INTEN: r_pwr_inten <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hdl/rcmg_queue.sv =====
module rcmg_queue #(
    parameter int P_DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rcmg_pkg::t_enq i_enq,
    input  logic           i_deq,
    output logic           o_full,
    output rcmg_pkg::t_head o_head
);

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    rcmg_pkg::t_rec r_mem [P_DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full       = (r_cnt == CW'(P_DEPTH));
    assign o_head.empty = (r_cnt == '0);
    assign o_head.rec   = r_mem[r_rd];
    assign do_push      = i_enq.push && !o_full;
    assign do_pop       = i_deq && !o_head.empty;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
        return (ptr == AW'(P_DEPTH - 1)) ? '0 : ptr + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_enq.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== hdl/rcmg_back.sv =====
module rcmg_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rcmg_pkg::t_head i_head,
    input  logic            i_pop,
    output logic            o_deq,
    output logic            o_empty,
    output logic            o_byte_valid,
    output logic [7:0]      o_tx_byte,
    output logic            o_last_of_run,
    output logic            o_accepted,
    output logic [2:0]      o_mode_now,
    output logic [16:0]     o_baud_rate_now
);

    // Byte position within the command at the head of the queue.
    logic [2:0] r_idx;
    logic       take;
    logic       last;

    assign last  = (r_idx == i_head.rec.last_idx);
    assign take  = i_pop && !i_head.empty;
    assign o_deq = take && last;

    assign o_empty         = i_head.empty;
    assign o_byte_valid    = i_head.rec.acc;
    assign o_tx_byte       = i_head.rec.bytes[r_idx];
    assign o_last_of_run   = last;
    assign o_accepted      = i_head.rec.acc;
    assign o_mode_now      = i_head.rec.mode;
    assign o_baud_rate_now = i_head.rec.baud;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (take) begin
            r_idx <= last ? 3'd0 : r_idx + 3'd1;
        end
    end

endmodule

// ===== sim/command_frame_checker.sv =====
module command_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [3:0]  i_op,
    input  logic [7:0]  i_baud_code,
    input  logic [15:0] i_velocity,
    input  logic [15:0] i_turn_radius,
    input  logic        i_main_brush_on,
    input  logic        i_vacuum_on,
    input  logic        i_side_brush_on,
    input  logic [7:0]  i_song_number,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_byte_valid,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_last_of_run,
    input  logic        i_accepted,
    input  logic [2:0]  i_mode_now,
    input  logic [16:0] i_baud_rate_now,
    output int          o_pending,
    output int          o_mismatches
);

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  tx_byte;
        logic        last_of_run;
        logic        accepted;
        logic [2:0]  mode_now;
        logic [16:0] baud_rate_now;
    } t_tx_beat;

    localparam logic [16:0] LINK_RATES [0:11] = '{
        17'd300, 17'd600, 17'd1200, 17'd2400, 17'd4800, 17'd9600,
        17'd14400, 17'd19200, 17'd28800, 17'd38400, 17'd57600, 17'd115200
    };

    logic [2:0]  link_mode;
    logic [16:0] link_rate;
    logic [5:0]  led_bits;
    logic [7:0]  led_color;
    logic [7:0]  led_intensity;
    t_tx_beat    expected_tx_q [$];
    int          pending_count = 0;
    int          mismatch_count = 0;

    assign o_pending    = pending_count;
    assign o_mismatches = mismatch_count;

    // Gates one command against the current mode and queues the bytes it sends.
    task automatic frame_command();
        logic [7:0] frame [0:4];
        int         n;
        logic       in_drive;
        t_tx_beat   beat;
        n = 0;
        in_drive = (link_mode == rcmg_pkg::MODE_SAFE) || (link_mode == rcmg_pkg::MODE_FULL);
        unique case (i_op)
            rcmg_pkg::OP_START: begin
                frame[0] = rcmg_pkg::TX_START;
                n = 1;
                link_mode = rcmg_pkg::MODE_PASSIVE;
            end
            rcmg_pkg::OP_BAUD: begin
                if ((link_mode == rcmg_pkg::MODE_PASSIVE || in_drive) &&
                    i_baud_code < rcmg_pkg::BAUD_CODE_LIMIT) begin
                    frame[0] = rcmg_pkg::TX_BAUD;
                    frame[1] = i_baud_code;
                    n = 2;
                    link_rate = LINK_RATES[i_baud_code[3:0]];
                end
            end
            rcmg_pkg::OP_CONTROL: begin
                if (link_mode == rcmg_pkg::MODE_PASSIVE) begin
                    frame[0] = rcmg_pkg::TX_CONTROL;
                    n = 1;
                    link_mode = rcmg_pkg::MODE_SAFE;
                end
            end
            rcmg_pkg::OP_SAFE: begin
                if (link_mode == rcmg_pkg::MODE_FULL) begin
                    frame[0] = rcmg_pkg::TX_SAFE;
                    n = 1;
                    link_mode = rcmg_pkg::MODE_SAFE;
                end
            end
            rcmg_pkg::OP_FULL: begin
                if (link_mode == rcmg_pkg::MODE_SAFE) begin
                    frame[0] = rcmg_pkg::TX_FULL;
                    n = 1;
                    link_mode = rcmg_pkg::MODE_FULL;
                end
            end
            rcmg_pkg::OP_POWER: begin
                if (in_drive) begin
                    frame[0] = rcmg_pkg::TX_POWER;
                    n = 1;
                    link_mode = rcmg_pkg::MODE_SLEEP;
                end
            end
            rcmg_pkg::OP_SPOT, rcmg_pkg::OP_CLEAN, rcmg_pkg::OP_MAX: begin
                if (in_drive) begin
                    frame[0] = (i_op == rcmg_pkg::OP_SPOT)  ? rcmg_pkg::TX_SPOT :
                               (i_op == rcmg_pkg::OP_CLEAN) ? rcmg_pkg::TX_CLEAN :
                                                              rcmg_pkg::TX_MAX;
                    n = 1;
                    link_mode = rcmg_pkg::MODE_PASSIVE;
                end
            end
            rcmg_pkg::OP_DRIVE: begin
                if (in_drive) begin
                    frame[0] = rcmg_pkg::TX_DRIVE;
                    frame[1] = i_velocity[15:8];
                    frame[2] = i_velocity[7:0];
                    frame[3] = i_turn_radius[15:8];
                    frame[4] = i_turn_radius[7:0];
                    n = 5;
                end
            end
            rcmg_pkg::OP_MOTORS: begin
                if (in_drive) begin
                    frame[0] = rcmg_pkg::TX_MOTORS;
                    frame[1] = {5'd0, i_main_brush_on, i_vacuum_on, i_side_brush_on};
                    n = 2;
                end
            end
            rcmg_pkg::OP_LEDS: begin
                if (in_drive) begin
                    frame[0] = rcmg_pkg::TX_LEDS;
                    frame[1] = {2'd0, led_bits};
                    frame[2] = led_color;
                    frame[3] = led_intensity;
                    n = 4;
                end
            end
            rcmg_pkg::OP_PLAY: begin
                if (i_song_number <= rcmg_pkg::SONG_MAX && in_drive) begin
                    frame[0] = rcmg_pkg::TX_PLAY;
                    frame[1] = i_song_number;
                    n = 2;
                end
            end
            rcmg_pkg::OP_DOCK: begin
                frame[0] = rcmg_pkg::TX_DOCK;
                n = 1;
            end
            default: begin
            end
        endcase

        // A refused command still yields one beat, with no byte on it.
        if (n == 0) begin
            beat = '{1'b0, 8'd0, 1'b1, 1'b0, link_mode, link_rate};
            expected_tx_q.push_back(beat);
        end else begin
            for (int k = 0; k < n; k++) begin
                beat = '{1'b1, frame[k], (k == n - 1), 1'b1, link_mode, link_rate};
                expected_tx_q.push_back(beat);
            end
        end
    endtask

    task automatic check_beat();
        t_tx_beat seen;
        t_tx_beat want;
        seen = '{i_byte_valid, i_tx_byte, i_last_of_run, i_accepted, i_mode_now,
                 i_baud_rate_now};
        if (expected_tx_q.size() == 0) begin
            if (mismatch_count < 10) begin
                $display({"ERROR: unexpected beat valid %0b byte %0d last %0b",
                          " acc %0b mode %0d baud %0d"},
                         seen.byte_valid, seen.tx_byte, seen.last_of_run, seen.accepted,
                         seen.mode_now, seen.baud_rate_now);
            end
            mismatch_count++;
        end else begin
            want = expected_tx_q.pop_front();
            if (seen !== want) begin
                if (mismatch_count < 10) begin
                    $display({"ERROR: expected valid %0b byte %0d last %0b",
                              " acc %0b mode %0d baud %0d"},
                             want.byte_valid, want.tx_byte, want.last_of_run, want.accepted,
                             want.mode_now, want.baud_rate_now);
                    $display({"       got      valid %0b byte %0d last %0b",
                              " acc %0b mode %0d baud %0d"},
                             seen.byte_valid, seen.tx_byte, seen.last_of_run, seen.accepted,
                             seen.mode_now, seen.baud_rate_now);
                end
                mismatch_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            link_mode     = rcmg_pkg::MODE_SLEEP;
            link_rate     = rcmg_pkg::BAUD_RESET;
            led_bits      = rcmg_pkg::LED_BITS_RESET;
            led_color     = rcmg_pkg::PWR_COLOR_RESET;
            led_intensity = rcmg_pkg::PWR_INTEN_RESET;
            expected_tx_q.delete();
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rcmg_pkg::REG_LED_BITS:  led_bits = i_cfg_data[5:0];
                    rcmg_pkg::REG_PWR_COLOR: led_color = i_cfg_data;
                    rcmg_pkg::REG_PWR_INTEN: led_intensity = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_pop && !i_empty) begin
                check_beat();
            end
            if (i_push && !i_full) begin
                frame_command();
            end
        end
        pending_count = expected_tx_q.size();
    end

endmodule

// ===== sim/tb_robot_command_mode_gate_encoder_unit.sv =====
module tb_robot_command_mode_gate_encoder_unit;

    // The limit covers the slowest legal run, about a hundred and twenty commands,
    // each up to five bytes, with each byte held off by a pop stall, and leaves a
    // wide margin.
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 23;
    localparam int SETTLE_CYCLES    = 16;

    // Commands that make up the middle of a session once the link is in safe
    // or full mode, and the commands that may close a session.
    localparam logic [3:0] BODY_OPS [0:9] = '{
        rcmg_pkg::OP_BAUD, rcmg_pkg::OP_DRIVE, rcmg_pkg::OP_DRIVE, rcmg_pkg::OP_MOTORS,
        rcmg_pkg::OP_LEDS, rcmg_pkg::OP_PLAY, rcmg_pkg::OP_PLAY, rcmg_pkg::OP_DOCK,
        rcmg_pkg::OP_SAFE, rcmg_pkg::OP_FULL
    };
    localparam logic [3:0] CLOSE_OPS [0:3] = '{
        rcmg_pkg::OP_POWER, rcmg_pkg::OP_SPOT, rcmg_pkg::OP_CLEAN, rcmg_pkg::OP_MAX
    };

    // One host command, with every payload field of the block.
    typedef struct packed {
        logic [3:0]  op;
        logic [7:0]  baud_code;
        logic [15:0] velocity;
        logic [15:0] turn_radius;
        logic        main_brush_on;
        logic        vacuum_on;
        logic        side_brush_on;
        logic [7:0]  song_number;
    } t_host_cmd;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = rcmg_pkg::REG_LED_BITS;
    logic [7:0]  cfg_data = 8'd0;
    logic        push = 1'b0;
    logic        full;
    logic [3:0]  op = rcmg_pkg::OP_START;
    logic [7:0]  baud_code = 8'd0;
    logic [15:0] velocity = 16'd0;
    logic [15:0] turn_radius = 16'd0;
    logic        main_brush_on = 1'b0;
    logic        vacuum_on = 1'b0;
    logic        side_brush_on = 1'b0;
    logic [7:0]  song_number = 8'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic        byte_valid;
    logic [7:0]  tx_byte;
    logic        last_of_run;
    logic        accepted;
    logic [2:0]  mode_now;
    logic [16:0] baud_rate_now;

    int pending;
    int mismatches;
    int commands_sent = 0;
    int cycle_count = 0;
    int pop_stall = 0;
    bit quiet_tail = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    robot_command_mode_gate_encoder_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_push          (push),
        .o_full          (full),
        .i_op            (op),
        .i_baud_code     (baud_code),
        .i_velocity      (velocity),
        .i_turn_radius   (turn_radius),
        .i_main_brush_on (main_brush_on),
        .i_vacuum_on     (vacuum_on),
        .i_side_brush_on (side_brush_on),
        .i_song_number   (song_number),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_byte_valid    (byte_valid),
        .o_tx_byte       (tx_byte),
        .o_last_of_run   (last_of_run),
        .o_accepted      (accepted),
        .o_mode_now      (mode_now),
        .o_baud_rate_now (baud_rate_now)
    );

    // The checker watches both channels and the register port on its own;
    // this module only makes stimulus and gives the verdict.
    command_frame_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_push          (push),
        .i_full          (full),
        .i_op            (op),
        .i_baud_code     (baud_code),
        .i_velocity      (velocity),
        .i_turn_radius   (turn_radius),
        .i_main_brush_on (main_brush_on),
        .i_vacuum_on     (vacuum_on),
        .i_side_brush_on (side_brush_on),
        .i_song_number   (song_number),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_byte_valid    (byte_valid),
        .i_tx_byte       (tx_byte),
        .i_last_of_run   (last_of_run),
        .i_accepted      (accepted),
        .i_mode_now      (mode_now),
        .i_baud_rate_now (baud_rate_now),
        .o_pending       (pending),
        .o_mismatches    (mismatches)
    );

    // Builds a command with random payload. Baud codes and song numbers are
    // mostly in their legal ranges so that most of them get past the gate,
    // but a quarter of them span the whole byte to hit the refusal paths.
    function automatic t_host_cmd random_cmd(input logic [3:0] code);
        t_host_cmd c;
        c.op            = code;
        c.baud_code     = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 11))
                                                      : 8'($urandom_range(0, 255));
        c.velocity      = 16'($urandom);
        c.turn_radius   = 16'($urandom);
        c.main_brush_on = 1'($urandom_range(0, 1));
        c.vacuum_on     = 1'($urandom_range(0, 1));
        c.side_brush_on = 1'($urandom_range(0, 1));
        c.song_number   = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15))
                                                      : 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Offers one command and holds it until the block takes it. Push stays
    // high straight into the next command unless a gap burst is drawn, so
    // back-to-back transactions are exercised as well as sparse ones.
    task automatic send(input t_host_cmd c);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        push          <= 1'b1;
        op            <= c.op;
        baud_code     <= c.baud_code;
        velocity      <= c.velocity;
        turn_radius   <= c.turn_radius;
        main_brush_on <= c.main_brush_on;
        vacuum_on     <= c.vacuum_on;
        side_brush_on <= c.side_brush_on;
        song_number   <= c.song_number;
        do @(posedge clk); while (full);
        commands_sent++;
    endtask

    // Stops offering commands and waits for the checker to have seen every
    // byte it expects. The count is read at the falling edge, where it is
    // stable, and the task returns on a rising edge ready to drive again.
    task automatic drain();
        push <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    // Writes all three LED registers in consecutive cycles. Only called
    // while the block is idle.
    task automatic program_leds(input logic [7:0] bits, input logic [7:0] color,
                                input logic [7:0] intensity);
        cfg_we   <= 1'b1;
        cfg_idx  <= rcmg_pkg::REG_LED_BITS;
        cfg_data <= bits;
        @(posedge clk);
        cfg_idx  <= rcmg_pkg::REG_PWR_COLOR;
        cfg_data <= color;
        @(posedge clk);
        cfg_idx  <= rcmg_pkg::REG_PWR_INTEN;
        cfg_data <= intensity;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // A session is a well-formed climb into safe mode (and sometimes full
    // mode), a run of drive-level commands with random content, and an
    // optional command that drops the link out again. Some sessions start
    // with a stray command or skip the control step, and a sixth of the body
    // is random noise, so that broken sequences and refusals keep turning up.
    task automatic run_session();
        int body;
        int pick;
        if ($urandom_range(0, 9) == 0) begin
            send(random_cmd(4'($urandom_range(0, 15))));
        end
        send(random_cmd(rcmg_pkg::OP_START));
        if ($urandom_range(0, 7) != 0) begin
            send(random_cmd(rcmg_pkg::OP_CONTROL));
        end
        if ($urandom_range(0, 1) == 0) begin
            send(random_cmd(rcmg_pkg::OP_FULL));
        end
        body = $urandom_range(2, 6);
        repeat (body) begin
            pick = $urandom_range(0, 11);
            if (pick < 10) begin
                send(random_cmd(BODY_OPS[pick]));
            end else begin
                send(random_cmd(4'($urandom_range(0, 15))));
            end
        end
        pick = $urandom_range(0, 5);
        if (pick < 4) begin
            send(random_cmd(CLOSE_OPS[pick]));
        end
    endtask

    // The result side pops at random, with stall bursts, until the quiet tail of
    // the run where it pops every cycle.
    always @(posedge clk) begin
        if (pop_stall > 0) begin
            pop_stall--;
            pop <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            pop_stall = $urandom_range(1, 14) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("robot_command_mode_gate_encoder_unit: mismatch");
        $finish;
    end

    initial begin
        t_host_cmd c;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the LED registers at their reset values.
        // The link starts asleep, so drive and an undefined opcode are
        // refused, while seek-dock goes through in any mode.
        send(random_cmd(rcmg_pkg::OP_DRIVE));
        send(random_cmd(4'd14));
        send(random_cmd(rcmg_pkg::OP_DOCK));
        send(random_cmd(rcmg_pkg::OP_START));

        // Baud in passive mode: the top code is taken, the first invalid
        // code and the largest one are refused with the rate left alone.
        c = random_cmd(rcmg_pkg::OP_BAUD);
        c.baud_code = 8'd11;
        send(c);
        c.baud_code = rcmg_pkg::BAUD_CODE_LIMIT;
        send(c);
        c.baud_code = 8'd255;
        send(c);

        // Play and full both need more than passive mode.
        c = random_cmd(rcmg_pkg::OP_PLAY);
        c.song_number = 8'd3;
        send(c);
        send(random_cmd(rcmg_pkg::OP_FULL));
        send(random_cmd(rcmg_pkg::OP_CONTROL));
        send(random_cmd(rcmg_pkg::OP_FULL));

        // Drive with the signed extremes in both halves.
        c = random_cmd(rcmg_pkg::OP_DRIVE);
        c.velocity    = 16'h7FFF;
        c.turn_radius = 16'h8000;
        send(c);
        c.velocity    = 16'h8000;
        c.turn_radius = 16'h7FFF;
        send(c);

        c = random_cmd(rcmg_pkg::OP_MOTORS);
        c.main_brush_on = 1'b1;
        c.vacuum_on     = 1'b0;
        c.side_brush_on = 1'b1;
        send(c);
        c.main_brush_on = 1'b0;
        c.vacuum_on     = 1'b1;
        c.side_brush_on = 1'b0;
        send(c);
        send(random_cmd(rcmg_pkg::OP_LEDS));

        // The highest song slot plays, the next one up is refused.
        c = random_cmd(rcmg_pkg::OP_PLAY);
        c.song_number = rcmg_pkg::SONG_MAX;
        send(c);
        c.song_number = rcmg_pkg::SONG_MAX + 8'd1;
        send(c);

        send(random_cmd(rcmg_pkg::OP_SAFE));
        c = random_cmd(rcmg_pkg::OP_BAUD);
        c.baud_code = 8'd0;
        send(c);

        // Spot, clean, max and power, each a drive-level way back out of safe mode.
        send(random_cmd(rcmg_pkg::OP_SPOT));
        send(random_cmd(rcmg_pkg::OP_CONTROL));
        send(random_cmd(rcmg_pkg::OP_CLEAN));
        send(random_cmd(rcmg_pkg::OP_CONTROL));
        send(random_cmd(rcmg_pkg::OP_MAX));
        send(random_cmd(rcmg_pkg::OP_CONTROL));
        send(random_cmd(rcmg_pkg::OP_POWER));
        drain();

        // Random phases, each with its own LED register setting: all ones,
        // all zeros, then two random settings. The last phase runs with no
        // idling on either side.
        for (int phase = 0; phase < 4; phase++) begin
            unique case (phase)
                0: begin
                    program_leds(8'd63, 8'd255, 8'd255);
                end
                1: begin
                    program_leds(8'd0, 8'd0, 8'd0);
                end
                default: begin
                    program_leds(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
                end
            endcase
            quiet_tail = (phase == 3);
            c.song_number = 8'd0;
            while (commands_sent < 27 + (phase + 1) * RANDOM_PER_PHASE) begin
                run_session();
            end
            drain();
        end

        // Any byte the block sends after the last expected one shows up here
        // as an unexpected transaction in the checker.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("robot_command_mode_gate_encoder_unit: match");
        end else begin
            $display("robot_command_mode_gate_encoder_unit: mismatch");
        end
        $finish;
    end

endmodule
